// ----- hw/rtl/fehm_pkg.sv -----
// Shared types, constants and helpers for the fire effect heat map unit.
`timescale 1ns / 1ps

package fehm_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);

    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int DIM_W  = 7;
    localparam int HEAT_W = 8;
    localparam int CFG_W  = 8;
    localparam int RAND_W = 16;

    // Four neighbor taps per cell, sum of four bytes.
    localparam int NUM_TAPS = 4;
    localparam int TAP_W    = $clog2(NUM_TAPS);
    localparam int SUM_W    = 10;
    localparam int FACTOR_W = 9;
    localparam int PROD_W   = SUM_W + FACTOR_W;

    localparam int RAND_OFFSET     = 32768;
    localparam int DEFAULT_PALETTE = 10;
    localparam int SCALE_BASE      = 200;
    localparam int SCALE_DIV       = 1000;
    localparam int HEAT_MAX        = 255;
    localparam int SAT_LIMIT       = (HEAT_MAX + 1) * SCALE_DIV;

    // Reciprocal of the scale divisor, rounded down; one correction step follows.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_K     = (1 << RECIP_SHIFT) / SCALE_DIV;
    localparam int RECIP_W     = PROD_W + 11;
    localparam int QUOT_W      = 9;

    // Remainder unit operand sizes.
    localparam int MOD_DVD_W = RAND_W + 1;
    localparam int MOD_CNT_W = $clog2(MOD_DVD_W + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd3;

    typedef struct packed {
        logic               bottom;
        logic               last;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col_l;
        logic [COL_W-1:0]   col_r;
        logic [ROW_W-1:0]   row_1;
        logic [ROW_W-1:0]   row_2;
        logic [RAND_W-1:0]  random_value;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] multiplier;
        logic [CFG_W-1:0] color_count;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [MOD_DVD_W-1:0]  dividend;
        logic [MOD_CNT_W-1:0]  nbits;
        logic [HEAT_W-1:0]     divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [HEAT_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

// ----- hw/rtl/fehm_front.sv -----
// Front end: configuration registers, frame walk and neighbor coordinates per cell.
`timescale 1ns / 1ps

module fehm_front
    import fehm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [RAND_W-1:0]    random_value,
    input  logic                 clear_done,
    input  logic                 q_ready,
    output logic                 q_push,
    output item_t                q_item,
    output cfg_t                 cfg
);

    logic [CFG_W-1:0] multiplier_reg;
    logic [CFG_W-1:0] color_count_reg;
    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic [COL_W-1:0] walk_col_reg, walk_col_next;
    logic [ROW_W-1:0] walk_row_reg, walk_row_next;
    logic             bottom_reg, bottom_next;

    logic [DIM_W-1:0] w_eff, h_eff, w_m1, h_m1;
    logic [DIM_W-1:0] x_inc, y1_inc, y2_inc, wr_inc;
    logic [ROW_W-1:0] y_cur, row_1;
    logic             wrap, frame_end;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (grid_width_reg > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = grid_width_reg;

        if (grid_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (grid_height_reg > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = grid_height_reg;
    end

    assign w_m1   = w_eff - DIM_W'(1);
    assign h_m1   = h_eff - DIM_W'(1);
    assign x_inc  = DIM_W'(walk_col_reg) + DIM_W'(1);
    assign y_cur  = bottom_reg ? h_m1[ROW_W-1:0] : walk_row_reg;
    assign y1_inc = DIM_W'(y_cur) + DIM_W'(1);
    assign row_1  = (y1_inc == h_eff) ? '0 : y1_inc[ROW_W-1:0];
    assign y2_inc = DIM_W'(row_1) + DIM_W'(1);
    assign wr_inc = DIM_W'(walk_row_reg) + DIM_W'(1);
    assign wrap   = (x_inc >= w_eff);

    always_comb
    begin
        q_item.bottom       = bottom_reg;
        q_item.col          = walk_col_reg;
        q_item.row          = y_cur;
        q_item.col_l        = (walk_col_reg == '0) ? w_m1[COL_W-1:0]
                                                   : walk_col_reg - COL_W'(1);
        q_item.col_r        = wrap ? '0 : x_inc[COL_W-1:0];
        q_item.row_1        = row_1;
        q_item.row_2        = (y2_inc == h_eff) ? '0 : y2_inc[ROW_W-1:0];
        q_item.random_value = random_value;

        walk_col_next = wrap ? '0 : x_inc[COL_W-1:0];
        walk_row_next = walk_row_reg;
        bottom_next   = bottom_reg;
        frame_end     = 1'b0;
        if (wrap)
        begin
            if (bottom_reg)
            begin
                walk_row_next = '0;
                if (h_eff == DIM_W'(1))
                    frame_end = 1'b1;
                else
                    bottom_next = 1'b0;
            end
            else if (wr_inc >= h_m1)
            begin
                frame_end     = 1'b1;
                walk_row_next = '0;
                bottom_next   = 1'b1;
            end
            else
            begin
                walk_row_next = wr_inc[ROW_W-1:0];
            end
        end
        q_item.last = frame_end;
    end

    assign s_tready = clear_done && q_ready;
    assign q_push   = s_tvalid && s_tready;

    assign cfg.multiplier  = multiplier_reg;
    assign cfg.color_count = color_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multiplier_reg  <= '0;
            color_count_reg <= '0;
            grid_width_reg  <= DIM_W'(MAX_WIDTH);
            grid_height_reg <= DIM_W'(MAX_HEIGHT);
            walk_col_reg    <= '0;
            walk_row_reg    <= '0;
            bottom_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MULTIPLIER:  multiplier_reg  <= cfg_data;
                REG_COLOR_COUNT: color_count_reg <= cfg_data;
                REG_GRID_WIDTH:
                begin
                    grid_width_reg <= cfg_data[DIM_W-1:0];
                    walk_col_reg   <= '0;
                    walk_row_reg   <= '0;
                    bottom_reg     <= 1'b1;
                end
                REG_GRID_HEIGHT:
                begin
                    grid_height_reg <= cfg_data[DIM_W-1:0];
                    walk_col_reg    <= '0;
                    walk_row_reg    <= '0;
                    bottom_reg      <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (q_push)
        begin
            walk_col_reg <= walk_col_next;
            walk_row_reg <= walk_row_next;
            bottom_reg   <= bottom_next;
        end
    end

endmodule

// ----- hw/rtl/fehm_queue.sv -----
// Two-entry queue of classified cells between the front end and the back end.
`timescale 1ns / 1ps

module fehm_queue
    import fehm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  pop,
    output item_t head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && out_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !(pop && out_valid))
                count_reg <= count_reg + 2'd1;
            else if (!push && pop && out_valid)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- hw/rtl/fehm_mod.sv -----
// Bit-serial remainder unit: one dividend bit per cycle against an 8-bit divisor.
`timescale 1ns / 1ps

module fehm_mod
    import fehm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_DVD_W-1:0] dvd_reg;
    logic [HEAT_W-1:0]    div_reg;
    logic [HEAT_W-1:0]    rem_reg;
    logic [HEAT_W:0]      trial, diff;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[MOD_DVD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.nbits;
                dvd_reg  <= req.dividend;
                div_reg  <= req.divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[HEAT_W-1:0] : trial[HEAT_W-1:0];
                dvd_reg <= {dvd_reg[MOD_DVD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/fehm_back.sv -----
// Back end: heat memory, clearing pass, neighbor sum, scaling, palette index and result register.
`timescale 1ns / 1ps

module fehm_back
    import fehm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              clear_done,
    output mod_req_t          mod_req,
    input  mod_rsp_t          mod_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [COL_W-1:0]  out_column,
    output logic [ROW_W-1:0]  out_row,
    output logic [HEAT_W-1:0] out_heat,
    output logic [HEAT_W-1:0] out_color_index,
    output logic              m_tlast
);

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_LAST,
        B_MUL,
        B_DIV,
        B_CORR,
        B_PAL,
        B_MODWAIT,
        B_WRITE
    } state_t;

    state_t            state_reg;
    item_t             item_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [TAP_W-1:0]  tap_reg;
    logic              rd_pend_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] q0_reg;
    logic [HEAT_W-1:0] val_reg;
    logic [HEAT_W-1:0] idx_reg;
    logic              out_valid_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [HEAT_W-1:0] out_heat_reg;
    logic [HEAT_W-1:0] out_idx_reg;
    logic              out_last_reg;

    logic [HEAT_W-1:0] heat_mem [MAP_DEPTH];
    logic [HEAT_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [HEAT_W-1:0] mem_wdata;

    logic [FACTOR_W-1:0] factor;
    logic [RECIP_W-1:0]  recip_prod;
    logic [PROD_W-1:0]   corr_rem;
    logic [QUOT_W-1:0]   corr_q;
    logic                out_load;
    logic                pal_on;

    assign clear_done = (state_reg != B_CLEAR);
    assign q_pop      = (state_reg == B_IDLE);
    assign out_load   = (state_reg == B_WRITE) && (!out_valid_reg || m_tready);
    assign pal_on     = (cfg.color_count != '0);

    assign factor     = FACTOR_W'(cfg.multiplier) + FACTOR_W'(SCALE_BASE);
    assign recip_prod = RECIP_W'(prod_reg) * RECIP_W'(RECIP_K);
    assign corr_rem   = prod_reg - PROD_W'(q0_reg) * PROD_W'(SCALE_DIV);
    assign corr_q     = (corr_rem >= PROD_W'(SCALE_DIV)) ? q0_reg + QUOT_W'(1) : q0_reg;

    // Port address: sweep during clear, the four neighbor taps, then the cell itself.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = val_reg;
        case (state_reg)
            B_CLEAR:
            begin
                mem_addr  = clr_addr_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            B_READ:
            begin
                case (tap_reg)
                    2'd0:    mem_addr = cell_addr(item_reg.row_1, item_reg.col_l);
                    2'd1:    mem_addr = cell_addr(item_reg.row_1, item_reg.col);
                    2'd2:    mem_addr = cell_addr(item_reg.row_1, item_reg.col_r);
                    default: mem_addr = cell_addr(item_reg.row_2, item_reg.col);
                endcase
            end
            B_WRITE:
            begin
                mem_addr = cell_addr(item_reg.row, item_reg.col);
                mem_we   = out_load;
            end
            default: mem_addr = cell_addr(item_reg.row, item_reg.col);
        endcase
    end

    always_comb
    begin
        mod_req = '0;
        if (state_reg == B_IDLE && q_valid && q_item.bottom)
        begin
            mod_req.start    = 1'b1;
            mod_req.dividend = MOD_DVD_W'(q_item.random_value) + MOD_DVD_W'(RAND_OFFSET);
            mod_req.nbits    = MOD_CNT_W'(MOD_DVD_W);
            mod_req.divisor  = pal_on ? cfg.color_count : HEAT_W'(DEFAULT_PALETTE);
        end
        else if (state_reg == B_PAL && pal_on)
        begin
            mod_req.start    = 1'b1;
            mod_req.dividend = {val_reg, {(MOD_DVD_W-HEAT_W){1'b0}}};
            mod_req.nbits    = MOD_CNT_W'(HEAT_W);
            mod_req.divisor  = cfg.color_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            heat_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= heat_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            item_reg      <= '0;
            clr_addr_reg  <= '0;
            tap_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            sum_reg       <= '0;
            prod_reg      <= '0;
            q0_reg        <= '0;
            val_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_heat_reg  <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                B_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(MAP_DEPTH - 1))
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg    <= q_item;
                        tap_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        sum_reg     <= '0;
                        state_reg   <= q_item.bottom ? B_MODWAIT : B_READ;
                    end
                end
                B_READ:
                begin
                    tap_reg     <= tap_reg + TAP_W'(1);
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg)
                        sum_reg <= sum_reg + SUM_W'(rd_data_reg);
                    if (tap_reg == TAP_W'(NUM_TAPS - 1))
                        state_reg <= B_LAST;
                end
                B_LAST:
                begin
                    sum_reg   <= sum_reg + SUM_W'(rd_data_reg);
                    state_reg <= B_MUL;
                end
                B_MUL:
                begin
                    prod_reg  <= PROD_W'(sum_reg) * PROD_W'(factor);
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    q0_reg    <= recip_prod[RECIP_SHIFT +: QUOT_W];
                    state_reg <= B_CORR;
                end
                B_CORR:
                begin
                    if (prod_reg >= PROD_W'(SAT_LIMIT))
                        val_reg <= HEAT_W'(HEAT_MAX);
                    else
                        val_reg <= corr_q[HEAT_W-1:0];
                    state_reg <= B_PAL;
                end
                B_PAL:
                begin
                    if (pal_on)
                    begin
                        state_reg <= B_MODWAIT;
                    end
                    else
                    begin
                        idx_reg   <= val_reg;
                        state_reg <= B_WRITE;
                    end
                end
                B_MODWAIT:
                begin
                    if (mod_rsp.done)
                    begin
                        if (item_reg.bottom)
                            val_reg <= mod_rsp.rem;
                        idx_reg   <= mod_rsp.rem;
                        state_reg <= B_WRITE;
                    end
                end
                B_WRITE:
                begin
                    if (out_load)
                    begin
                        out_col_reg  <= item_reg.col;
                        out_row_reg  <= item_reg.row;
                        out_heat_reg <= val_reg;
                        out_idx_reg  <= idx_reg;
                        out_last_reg <= item_reg.last;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign out_column      = out_col_reg;
    assign out_row         = out_row_reg;
    assign out_heat        = out_heat_reg;
    assign out_color_index = out_idx_reg;
    assign m_tlast         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> state_reg == B_MODWAIT)
        else $error("remainder unit finished while the back end was not waiting");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !out_valid_reg)
        else $error("result presented during the clearing pass");

    a_bottom_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE && item_reg.bottom) |-> idx_reg == val_reg)
        else $error("bottom-row palette index differs from its heat");

    a_pop_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_pop) |-> clear_done)
        else $error("cell taken from the queue before the map was cleared");
`endif

endmodule

// ----- hw/rtl/fire_effect_heat_map_unit.sv -----
// Top level of the fire effect heat map unit: front end, queue, remainder unit and back end.
`timescale 1ns / 1ps

// Channel    Direction  Handshake           Payload
// s_axis     in         s_tvalid/s_tready   s_tdata[15:0] random_value
// m_axis     out        m_tvalid/m_tready   m_tdata column,row,heat,color_index; m_tlast
// cfg        in         cfg_we              cfg_index, cfg_data
//
// For an upper-row cell the back end does four reads and one write on the single
// heat memory port, a multiply and a reciprocal divide, and with a palette it runs
// the bit-serial remainder unit for the palette index. A bottom-row cell only runs
// the remainder unit on its random value and writes the result.
// After reset the memory is cleared one cell per cycle, all 4096 cells, with s_tready low.
// The two-entry queue and the result register let either side stall on its own.

module fire_effect_heat_map_unit
    import fehm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] random_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [5:0] column, [11:6] row, [19:12] heat,
                                            // [27:20] color_index, [31:28] zero
    output logic                 m_tlast
);

    cfg_t              cfg;
    item_t             push_item, head;
    logic              q_push, q_in_ready, q_valid, q_pop, clear_done;
    mod_req_t          mod_req;
    mod_rsp_t          mod_rsp;
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  out_row;
    logic [HEAT_W-1:0] out_heat, out_color_index;

    fehm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .random_value (s_tdata[RAND_W-1:0]),
        .clear_done   (clear_done),
        .q_ready      (q_in_ready),
        .q_push       (q_push),
        .q_item       (push_item),
        .cfg          (cfg)
    );

    fehm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .in_ready  (q_in_ready),
        .out_valid (q_valid),
        .pop       (q_pop),
        .head      (head)
    );

    fehm_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    fehm_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .q_valid         (q_valid),
        .q_item          (head),
        .q_pop           (q_pop),
        .clear_done      (clear_done),
        .mod_req         (mod_req),
        .mod_rsp         (mod_rsp),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_column      (out_column),
        .out_row         (out_row),
        .out_heat        (out_heat),
        .out_color_index (out_color_index),
        .m_tlast         (m_tlast)
    );

    assign m_tdata = {4'b0000, out_color_index, out_heat, out_row, out_column};

endmodule

// ----- test/fire_effect_heat_map_unit_tb.sv -----
// Self-checking testbench for the fire effect heat map unit, with its own model of the heat walk.
`timescale 1ns / 1ps

module fire_effect_heat_map_unit_tb;
    import fehm_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [HEAT_W-1:0] heat;
        logic [HEAT_W-1:0] cidx;
        logic              last;
    } cell_result_t;

    typedef enum bit {STIM_ITEM, STIM_WRITE} stim_kind_e;

    typedef struct packed {
        stim_kind_e           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [RAND_W-1:0]    rv;
        bit                   typed;
        cell_result_t         want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MULTIPLIER;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tlast;

    fire_effect_heat_map_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block state.
    logic [HEAT_W-1:0] heat_grid [0:MAP_DEPTH-1];
    logic [CFG_W-1:0]  flame_mult;
    logic [CFG_W-1:0]  palette_size;
    logic [DIM_W-1:0]  grid_w_reg;
    logic [DIM_W-1:0]  grid_h_reg;
    int                walk_col;
    int                walk_row;
    bit                bottom_pass;

    cell_result_t pending_cells [$];
    stim_row_t    warmup_rows [$];
    int           mismatch_count = 0;
    int           send_idle = 0;
    int           recv_idle = 0;

    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    function automatic void restart_walk();
        walk_col = 0;
        walk_row = 0;
        bottom_pass = 1'b1;
    endfunction

    function automatic void reset_fire_model();
        for (int i = 0; i < MAP_DEPTH; i++)
            heat_grid[i] = '0;
        flame_mult = '0;
        palette_size = '0;
        grid_w_reg = 7'd64;
        grid_h_reg = 7'd64;
        restart_walk();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_W-1:0] data);
        case (idx)
            REG_MULTIPLIER:  flame_mult = data;
            REG_COLOR_COUNT: palette_size = data;
            REG_GRID_WIDTH:
            begin
                grid_w_reg = data[DIM_W-1:0];
                restart_walk();
            end
            REG_GRID_HEIGHT:
            begin
                grid_h_reg = data[DIM_W-1:0];
                restart_walk();
            end
            default: ;
        endcase
    endfunction

    // Computes the next cell of the walk, updates the shadow map in place and advances the walk.
    function automatic cell_result_t next_fire_cell(input logic [RAND_W-1:0] rv);
        int w;
        int h;
        int x;
        int y;
        int m;
        int xl;
        int xr;
        int y1;
        int y2;
        int sum;
        int val;
        cell_result_t c;
        w = eff_dim(grid_w_reg, MAX_WIDTH);
        h = eff_dim(grid_h_reg, MAX_HEIGHT);
        x = walk_col;
        c.last = 1'b0;
        if (bottom_pass)
        begin
            m = (palette_size != 0) ? int'(palette_size) : DEFAULT_PALETTE;
            y = h - 1;
            val = (int'(rv) + RAND_OFFSET) % m;
        end
        else
        begin
            xl = (x + w - 1) % w;
            xr = (x + 1) % w;
            y = walk_row;
            y1 = (y + 1) % h;
            y2 = (y + 2) % h;
            sum = int'(heat_grid[y1 * MAX_WIDTH + xl]) + int'(heat_grid[y1 * MAX_WIDTH + x])
                + int'(heat_grid[y1 * MAX_WIDTH + xr]) + int'(heat_grid[y2 * MAX_WIDTH + x]);
            val = (sum * (int'(flame_mult) + SCALE_BASE)) / SCALE_DIV;
            if (val > HEAT_MAX)
                val = HEAT_MAX;
        end
        heat_grid[y * MAX_WIDTH + x] = val[HEAT_W-1:0];

        walk_col = x + 1;
        if (walk_col >= w)
        begin
            walk_col = 0;
            if (bottom_pass)
            begin
                walk_row = 0;
                if (h == 1)
                    c.last = 1'b1;
                else
                    bottom_pass = 1'b0;
            end
            else
            begin
                walk_row = y + 1;
                if (walk_row >= h - 1)
                begin
                    c.last = 1'b1;
                    walk_row = 0;
                    bottom_pass = 1'b1;
                end
            end
        end

        c.col = x[COL_W-1:0];
        c.row = y[ROW_W-1:0];
        c.heat = val[HEAT_W-1:0];
        c.cidx = (palette_size != 0) ? HEAT_W'(val % int'(palette_size)) : val[HEAT_W-1:0];
        return c;
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = STIM_WRITE;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic [RAND_W-1:0] rv);
        stim_row_t r;
        r = '0;
        r.kind = STIM_ITEM;
        r.rv = rv;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [RAND_W-1:0] rv,
                                            input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row,
                                            input logic [HEAT_W-1:0] heat,
                                            input logic [HEAT_W-1:0] cidx,
                                            input logic last);
        stim_row_t r;
        r = item_row(rv);
        r.typed = 1'b1;
        r.want = '{col, row, heat, cidx, last};
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        logic [DIM_W-1:0] d;
        case ($urandom_range(7))
            0: d = '0;
            1: d = DIM_W'($urandom_range(65, 127));
            2: d = 7'd64;
            default: d = DIM_W'($urandom_range(1, 6));
        endcase
        // The top data bit is outside the register and must be dropped.
        return {1'($urandom_range(1)), d};
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic send_item(input logic [RAND_W-1:0] rv, input bit typed,
                             input cell_result_t want);
        cell_result_t predicted;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rv;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predicted = next_fire_cell(rv);
        pending_cells.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        cell_result_t got;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got = '{m_tdata[5:0], m_tdata[11:6], m_tdata[19:12], m_tdata[27:20], m_tlast};
            if (pending_cells.size() == 0)
                report_mismatch($sformatf("unexpected cell (%0d,%0d) heat %0d",
                                          got.col, got.row, got.heat));
            else
            begin
                want = pending_cells.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "exp col %0d row %0d heat %0d idx %0d last %0b, got %0d %0d %0d %0d %0b",
                        want.col, want.row, want.heat, want.cidx, want.last,
                        got.col, got.row, got.heat, got.cidx, got.last));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        int count;
        logic [RAND_W-1:0] rv;
        reset_fire_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 25;
        recv_idle = 80;
        warmup_rows = '{
            typed_row(16'h0000, 0, 63, 8, 8, 1'b0),
            // Single column, single row: every cell closes a frame.
            write_row(REG_GRID_WIDTH, 8'd1),
            write_row(REG_GRID_HEIGHT, 8'd1),
            typed_row(16'hFFFF, 0, 0, 3, 3, 1'b1),
            // Two rows at full gain: the upper cell saturates.
            write_row(REG_COLOR_COUNT, 8'd255),
            write_row(REG_MULTIPLIER, 8'd255),
            write_row(REG_GRID_HEIGHT, 8'd2),
            typed_row(16'd126, 0, 1, 254, 254, 1'b0),
            typed_row(16'h5A5A, 0, 0, 255, 0, 1'b1),
            // Zero sizes act as one; bit 7 of the height write is dropped.
            write_row(REG_GRID_WIDTH, 8'd0),
            write_row(REG_GRID_HEIGHT, 8'h80),
            typed_row(16'h0000, 0, 0, 128, 128, 1'b1),
            write_row(REG_COLOR_COUNT, 8'd1),
            typed_row(16'h1234, 0, 0, 0, 0, 1'b1),
            write_row(REG_MULTIPLIER, 8'd0),
            write_row(REG_COLOR_COUNT, 8'd0),
            write_row(REG_GRID_WIDTH, 8'd3),
            write_row(REG_GRID_HEIGHT, 8'd3),
            item_row(16'h8000), item_row(16'h7FFF), item_row(16'h0001),
            item_row(16'hFFFE), item_row(16'hAAAA), item_row(16'h5555),
            item_row(16'h00FF), item_row(16'hFF00), item_row(16'h0F0F),
            // Width above the maximum acts as the maximum.
            write_row(REG_GRID_WIDTH, 8'd127),
            write_row(REG_GRID_HEIGHT, 8'd1),
            typed_row(16'h0007, 0, 0, 5, 5, 1'b0)
        };
        foreach (warmup_rows[i])
        begin
            if (warmup_rows[i].kind == STIM_WRITE)
            begin
                wait_drained();
                write_reg(warmup_rows[i].idx, warmup_rows[i].data);
            end
            else
                send_item(warmup_rows[i].rv, warmup_rows[i].typed, warmup_rows[i].want);
        end

        for (int stage = 0; stage < 3; stage++)
        begin
            send_idle = (stage == 0) ? 25 : (stage == 1) ? 80 : 0;
            recv_idle = (stage == 0) ? 80 : (stage == 1) ? 25 : 0;
            for (int p = 0; p < 4; p++)
            begin
                wait_drained();
                if (p == 0)
                begin
                    write_reg(REG_MULTIPLIER, 8'd0);
                    write_reg(REG_COLOR_COUNT, 8'd0);
                    write_reg(REG_GRID_WIDTH, 8'd127);
                    write_reg(REG_GRID_HEIGHT, 8'd2);
                end
                else if (p == 1)
                begin
                    write_reg(REG_MULTIPLIER, 8'd255);
                    write_reg(REG_COLOR_COUNT, 8'd255);
                    write_reg(REG_GRID_WIDTH, 8'd1);
                    write_reg(REG_GRID_HEIGHT, 8'd64);
                end
                else
                begin
                    write_reg(REG_MULTIPLIER, CFG_W'($urandom_range(255)));
                    write_reg(REG_COLOR_COUNT,
                              ($urandom_range(3) == 0) ? '0 : CFG_W'($urandom_range(1, 255)));
                    // Leaving a size alone lets a frame carry on across the phase.
                    if ($urandom_range(2) != 0)
                        write_reg(REG_GRID_WIDTH, pick_dim());
                    if ($urandom_range(2) != 0)
                        write_reg(REG_GRID_HEIGHT, pick_dim());
                end
                count = $urandom_range(100, 180);
                for (int n = 0; n < count; n++)
                begin
                    rv = ($urandom_range(15) == 0) ? {16{1'($urandom_range(1))}}
                                                   : RAND_W'($urandom_range(65535));
                    send_item(rv, 1'b0, '0);
                    if (n == count / 2)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
